### src/nmea_gga_pkg.sv
// shared types, constants and helper functions for the nmea gga parser
// no dependencies
`timescale 1ns / 1ps
package nmea_gga_pkg;

  localparam int unsigned MaxLine = 96;

  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChComma = 8'd44;
  localparam logic [7:0] ChNorth = 8'd78;
  localparam logic [7:0] ChEast  = 8'd69;

  typedef enum logic [2:0] {
    KIND_GSV = 3'd0,
    KIND_RMC = 3'd1,
    KIND_GSA = 3'd2,
    KIND_GGA = 3'd3,
    KIND_GLL = 3'd4,
    KIND_VTG = 3'd5,
    KIND_TXT = 3'd6,
    KIND_UNK = 3'd7
  } kind_e;

  // one coordinate being assembled from its digits
  typedef struct packed {
    logic [9:0]  deg;
    logic [6:0]  min;
    logic [16:0] frac;
    logic        pos;
  } coord_t;

  typedef struct packed {
    logic  fire;
    kind_e kind;
  } line_evt_t;

  function automatic kind_e kind_of(input logic [23:0] letters);
    kind_e k;
    begin
      unique case (letters)
        24'h475356: k = KIND_GSV;
        24'h524D43: k = KIND_RMC;
        24'h475341: k = KIND_GSA;
        24'h474741: k = KIND_GGA;
        24'h474C4C: k = KIND_GLL;
        24'h565447: k = KIND_VTG;
        24'h545854: k = KIND_TXT;
        default:    k = KIND_UNK;
      endcase
      return k;
    end
  endfunction

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [3:0] d;
    begin
      d = (c >= 8'd48 && c <= 8'd57) ? 4'(c - 8'd48) : 4'd0;
      return d;
    end
  endfunction

  function automatic logic [16:0] frac_term(input logic [3:0] d, input logic [6:0] k);
    logic [16:0] t;
    begin
      unique case (k)
        7'd0:    t = 17'(d * 17'd10000);
        7'd1:    t = 17'(d * 17'd1000);
        7'd2:    t = 17'(d * 17'd100);
        7'd3:    t = 17'(d * 17'd10);
        7'd4:    t = 17'(d);
        default: t = '0;
      endcase
      return t;
    end
  endfunction

  // one character of a ddmm.mmmmm style number, dl degree digits
  function automatic coord_t coord_step(input coord_t s, input logic [7:0] c,
                                        input logic [6:0] p, input logic [6:0] dl);
    coord_t     r;
    logic [3:0] d;
    begin
      r = s;
      d = digit_of(c);
      if (p < dl) begin
        r.deg = 10'(s.deg * 10'd10 + 10'(d));
      end else if (p < 7'(dl + 7'd2)) begin
        r.min = 7'(s.min * 7'd10 + 7'(d));
      end else if (p > 7'(dl + 7'd2)) begin
        r.frac = 17'(s.frac + frac_term(d, 7'(p - dl - 7'd3)));
      end
      return r;
    end
  endfunction

endpackage

### src/nmea_gga_lexer.sv
// line and field tracker: splits characters at commas and collects the coordinates
// depends on nmea_gga_pkg
`timescale 1ns / 1ps
module nmea_gga_lexer #(
  parameter int unsigned MaxLine = nmea_gga_pkg::MaxLine
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             rx_byte_i,
  output nmea_gga_pkg::line_evt_t evt_o,
  output nmea_gga_pkg::coord_t   lat_o,
  output nmea_gga_pkg::coord_t   lon_o
);
  import nmea_gga_pkg::*;

  logic        prev_cr_q, prev_cr_d;
  logic        ovf_q, ovf_d;
  logic [6:0]  len_q, len_d;
  logic [4:0]  fnum_q, fnum_d;
  logic [6:0]  fpos_q, fpos_d;
  logic [23:0] letters_q, letters_d;
  coord_t      lat_q, lat_d, lon_q, lon_d;

  logic        ovf_now;
  logic        line_end;
  logic [23:0] letters_fix;

  assign line_end    = (rx_byte_i == ChLf) && prev_cr_q;
  assign letters_fix = (fnum_q == 5'd0 && fpos_q != 7'd6) ? 24'd0 : letters_q;
  assign lat_o       = lat_q;
  assign lon_o       = lon_q;

  always_comb begin
    prev_cr_d  = prev_cr_q;
    ovf_d      = ovf_q;
    len_d      = len_q;
    fnum_d     = fnum_q;
    fpos_d     = fpos_q;
    letters_d  = letters_q;
    lat_d      = lat_q;
    lon_d      = lon_q;
    ovf_now    = ovf_q;
    evt_o.fire = 1'b0;
    evt_o.kind = kind_of(letters_fix);
    if (accept_i) begin
      if (len_q < 7'(MaxLine)) begin
        len_d = 7'(len_q + 7'd1);
      end else begin
        ovf_now = 1'b1;
      end
      if (line_end) begin
        evt_o.fire = !ovf_now;
        prev_cr_d  = 1'b0;
        ovf_d      = 1'b0;
        len_d      = '0;
        fnum_d     = '0;
        fpos_d     = '0;
        letters_d  = '0;
        lat_d      = '0;
        lon_d      = '0;
      end else begin
        ovf_d     = ovf_now;
        prev_cr_d = (rx_byte_i == ChCr);
        if (!ovf_now && rx_byte_i != ChCr) begin
          if (rx_byte_i == ChComma) begin
            if (fnum_q == 5'd0 && fpos_q != 7'd6) letters_d = '0;
            if (fnum_q < 5'd31) fnum_d = 5'(fnum_q + 5'd1);
            fpos_d = '0;
          end else begin
            unique case (fnum_q)
              5'd0: begin
                unique case (fpos_q)
                  7'd3:    letters_d = letters_q | {rx_byte_i, 16'd0};
                  7'd4:    letters_d = letters_q | {8'd0, rx_byte_i, 8'd0};
                  7'd5:    letters_d = letters_q | {16'd0, rx_byte_i};
                  default: letters_d = letters_q;
                endcase
              end
              5'd2: lat_d = coord_step(lat_q, rx_byte_i, fpos_q, 7'd2);
              5'd3: if (fpos_q == 7'd0) lat_d.pos = (rx_byte_i == ChNorth);
              5'd4: lon_d = coord_step(lon_q, rx_byte_i, fpos_q, 7'd3);
              5'd5: if (fpos_q == 7'd0) lon_d.pos = (rx_byte_i == ChEast);
              default: ;
            endcase
            if (fpos_q < 7'd127) fpos_d = 7'(fpos_q + 7'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cr_q <= 1'b0;
      ovf_q     <= 1'b0;
      len_q     <= '0;
      fnum_q    <= '0;
      fpos_q    <= '0;
      letters_q <= '0;
      lat_q     <= '0;
      lon_q     <= '0;
    end else begin
      prev_cr_q <= prev_cr_d;
      ovf_q     <= ovf_d;
      len_q     <= len_d;
      fnum_q    <= fnum_d;
      fpos_q    <= fpos_d;
      letters_q <= letters_d;
      lat_q     <= lat_d;
      lon_q     <= lon_d;
    end
  end

endmodule

### src/nmea_gga_conv.sv
// three-stage conversion of degrees, minutes and fraction to signed 1e-7 degree
// depends on nmea_gga_pkg
`timescale 1ns / 1ps
module nmea_gga_conv (
  input  logic                 clk_i,
  input  logic [2:0]           load_i,
  input  nmea_gga_pkg::coord_t coord_i,
  output logic [34:0]          value_o
);
  import nmea_gga_pkg::*;

  localparam logic [31:0] Recip3 = 32'hAAAAAAAB;

  coord_t      snap_q;
  logic [23:0] mins_q, mins_d;
  logic [33:0] degp_q, degp_d, degp2_q;
  logic        pos_q, pos2_q;
  logic [23:0] quot_q, quot_d;
  logic [26:0] five_x;
  logic [58:0] prod;
  logic [34:0] mag;

  // minutes scaled to 1e-5 minute
  assign mins_d = 24'(snap_q.min * 24'd100000) + 24'(snap_q.frac);
  assign degp_d = 34'(snap_q.deg * 34'd10000000);
  // floor(x * 10 / 6) as floor(5x / 3) by reciprocal
  assign five_x = 27'({mins_q, 2'b00}) + 27'(mins_q);
  assign prod   = 59'(five_x) * 59'(Recip3);
  assign quot_d = prod[56:33];
  assign mag    = 35'(degp2_q) + 35'(quot_q);
  assign value_o = pos2_q ? mag : 35'(35'd0 - mag);

  always_ff @(posedge clk_i) begin
    if (load_i[0]) snap_q <= coord_i;
    if (load_i[1]) begin
      mins_q <= mins_d;
      degp_q <= degp_d;
      pos_q  <= snap_q.pos;
    end
    if (load_i[2]) begin
      quot_q  <= quot_d;
      degp2_q <= degp_q;
      pos2_q  <= pos_q;
    end
  end

endmodule

### src/nmea_gga_position_parser_core.sv
// nmea gga parser top level: lexer, conversion pipeline and result register
// depends on nmea_gga_pkg, nmea_gga_lexer, nmea_gga_conv
//
//   channel  dir  tdata                                  tuser
//   s_axis   in   [7:0] rx_byte                          -
//   m_axis   out  [0] position_updated, [31:1] latitude  [2:0] sentence_kind
//                 [66:32] longitude, rest zero
//
// one character is taken every cycle while s_axis_tready is high; after the edge that
// takes its lf, a line result passes the snapshot, scale and divide-by-three registers
// of the converter and the add-into-result register, then shows on m_axis
// stages advance independently, so bubbles close up while the output stalls
// reset clears line state and the held position to zero
`timescale 1ns / 1ps
module nmea_gga_position_parser_core #(
  parameter int unsigned MaxLine = nmea_gga_pkg::MaxLine
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [0] position_updated, [31:1] latitude_e7,
                                      // [66:32] longitude_e7, [71:67] zero
  output logic [2:0]  m_axis_tuser    // [2:0] sentence_kind
);
  import nmea_gga_pkg::*;

  line_evt_t   evt;
  coord_t      lat_c, lon_c;
  logic        accept;
  logic [2:0]  v_q;
  logic        vo_q;
  kind_e       kind_q [3];
  logic        free1, free2, free3, free_o;
  logic        ld1, ld2, ld3, ld_o;
  logic [34:0] lat_val, lon_val;
  logic [30:0] lat_q;
  logic [34:0] lon_q;
  kind_e       kind_o_q;
  logic        upd_o_q;

  assign free_o = !vo_q || m_axis_tready;
  assign free3  = !v_q[2] || free_o;
  assign free2  = !v_q[1] || free3;
  assign free1  = !v_q[0] || free2;
  assign ld_o   = v_q[2] && free_o;
  assign ld3    = v_q[1] && free3;
  assign ld2    = v_q[0] && free2;
  assign s_axis_tready = free1;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign ld1    = evt.fire;

  nmea_gga_lexer #(
    .MaxLine (MaxLine)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata),
    .evt_o     (evt),
    .lat_o     (lat_c),
    .lon_o     (lon_c)
  );

  nmea_gga_conv u_conv_lat (
    .clk_i   (clk_i),
    .load_i  ({ld3, ld2, ld1}),
    .coord_i (lat_c),
    .value_o (lat_val)
  );

  nmea_gga_conv u_conv_lon (
    .clk_i   (clk_i),
    .load_i  ({ld3, ld2, ld1}),
    .coord_i (lon_c),
    .value_o (lon_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else begin
      if (free1) v_q[0] <= ld1;
      if (free2) v_q[1] <= v_q[0];
      if (free3) v_q[2] <= v_q[1];
      if (free_o) vo_q <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) kind_q[0] <= evt.kind;
    if (ld2) kind_q[1] <= kind_q[0];
    if (ld3) kind_q[2] <= kind_q[1];
  end

  // the result register doubles as the held position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q    <= '0;
      lon_q    <= '0;
      kind_o_q <= KIND_UNK;
      upd_o_q  <= 1'b0;
    end else if (ld_o) begin
      kind_o_q <= kind_q[2];
      upd_o_q  <= (kind_q[2] == KIND_GGA);
      if (kind_q[2] == KIND_GGA) begin
        lat_q <= lat_val[30:0];
        lon_q <= lon_val;
      end
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tuser  = kind_o_q;
  assign m_axis_tdata  = {5'd0, lon_q, lat_q, upd_o_q};

  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ld_o && kind_q[2] == KIND_GGA) |=> ($stable(lat_q) && $stable(lon_q)))
    else $error("held position changed without a gga result");

  a_upd_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (upd_o_q == (kind_o_q == KIND_GGA)))
    else $error("update flag disagrees with sentence kind");

  a_no_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !m_axis_tready) |=> vo_q)
    else $error("stalled result dropped");

endmodule

### dv/testbench.sv
// self-checking testbench for nmea_gga_position_parser_core: character streams in,
// line results out, checked against a built-in model of the parser
// depends on nmea_gga_pkg and nmea_gga_position_parser_core
`timescale 1ns / 1ps

module testbench;
  import nmea_gga_pkg::*;

  class line_result_board;
    bit          prev_cr, overflowed;
    int unsigned line_len, field_no, field_pos;
    logic [23:0] letters;
    longint unsigned lat_deg, lat_min, lat_frac, lon_deg, lon_min, lon_frac;
    bit          lat_north, lon_east;
    logic [31:0] held_lat;
    logic [34:0] held_lon;
    logic [2:0]  exp_kind[$];
    logic [71:0] exp_data[$];
    int          errors;
    int          lines_seen;
    int          gga_seen;

    function void clear_line();
      prev_cr = 0; overflowed = 0; line_len = 0; field_no = 0; field_pos = 0;
      letters = '0;
      lat_deg = 0; lat_min = 0; lat_frac = 0; lat_north = 0;
      lon_deg = 0; lon_min = 0; lon_frac = 0; lon_east = 0;
    endfunction

    function void reset_state();
      clear_line();
      held_lat = '0;
      held_lon = '0;
    endfunction

    function int unsigned digit(logic [7:0] c);
      return (c >= 8'd48 && c <= 8'd57) ? c - 48 : 0;
    endfunction

    function int unsigned weight(int unsigned k);
      case (k)
        0: return 10000;
        1: return 1000;
        2: return 100;
        3: return 10;
        4: return 1;
        default: return 0;
      endcase
    endfunction

    function void number_char(logic [7:0] c, int unsigned p, int unsigned dl,
                              inout longint unsigned dg, inout longint unsigned mn,
                              inout longint unsigned fr);
      int unsigned d;
      d = digit(c);
      if (p < dl) dg = dg * 10 + d;
      else if (p < dl + 2) mn = mn * 10 + d;
      else if (p > dl + 2) fr = fr + d * weight(p - dl - 3);
    endfunction

    function longint unsigned to_e7(longint unsigned dg, longint unsigned mn,
                                    longint unsigned fr, bit pos);
      longint unsigned mag;
      mag = dg * 10000000 + (mn * 100000 + fr) * 10 / 6;
      return pos ? mag : -mag;
    endfunction

    function void lex_char(logic [7:0] c);
      if (c == ChCr) return;
      if (c == ChComma) begin
        if (field_no == 0 && field_pos != 6) letters = '0;
        if (field_no < 31) field_no++;
        field_pos = 0;
        return;
      end
      case (field_no)
        0: if (field_pos >= 3 && field_pos <= 5)
             letters[8*(5-field_pos) +: 8] = letters[8*(5-field_pos) +: 8] | c;
        2: number_char(c, field_pos, 2, lat_deg, lat_min, lat_frac);
        3: if (field_pos == 0) lat_north = (c == ChNorth);
        4: number_char(c, field_pos, 3, lon_deg, lon_min, lon_frac);
        5: if (field_pos == 0) lon_east = (c == ChEast);
        default: ;
      endcase
      if (field_pos < 127) field_pos++;
    endfunction

    // note one accepted character; queues a line result when the line ends
    function void note_char(logic [7:0] c);
      kind_e k;
      if (line_len < MaxLine) line_len++;
      else overflowed = 1;
      if (c == ChLf && prev_cr) begin
        if (!overflowed) begin
          if (field_no == 0 && field_pos != 6) letters = '0;
          k = kind_of(letters);
          if (k == KIND_GGA) begin
            held_lat = 32'(to_e7(lat_deg, lat_min, lat_frac, lat_north));
            held_lon = 35'(to_e7(lon_deg, lon_min, lon_frac, lon_east));
            gga_seen++;
          end
          exp_kind.push_back(k);
          exp_data.push_back({5'd0, held_lon, held_lat[30:0], k == KIND_GGA});
          lines_seen++;
        end
        clear_line();
        return;
      end
      if (!overflowed) lex_char(c);
      prev_cr = (c == ChCr);
    endfunction

    function void check_line(logic [71:0] data, logic [2:0] kind);
      if (exp_kind.size() == 0) begin
        $display("%0t: unexpected line result data=%h kind=%0d", $time, data, kind);
        errors++;
        return;
      end
      if (kind !== exp_kind[0]) begin
        $display("%0t: sentence_kind expected %0d actual %0d", $time, exp_kind[0], kind);
        errors++;
      end
      if (data[0] !== exp_data[0][0]) begin
        $display("%0t: position_updated expected %0d actual %0d", $time,
                 exp_data[0][0], data[0]);
        errors++;
      end
      if (data[31:1] !== exp_data[0][31:1]) begin
        $display("%0t: latitude_e7 expected %h actual %h", $time,
                 exp_data[0][31:1], data[31:1]);
        errors++;
      end
      if (data[71:32] !== exp_data[0][71:32]) begin
        $display("%0t: longitude_e7 expected %h actual %h", $time,
                 exp_data[0][71:32], data[71:32]);
        errors++;
      end
      void'(exp_kind.pop_front());
      void'(exp_data.pop_front());
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  line_result_board board = new();
  int  chars_sent = 0;
  bit  calm = 0;

  always #5 clk_i = ~clk_i;

  nmea_gga_position_parser_core DUT (.*);

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  function bit idle_now();
    return !calm && ($urandom_range(99) < 21);
  endfunction

  // sink side: random back-pressure, checks at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_line(m_axis_tdata, m_axis_tuser);
  end
  always @(negedge clk_i) m_axis_tready <= !idle_now();

  // called and left at a falling edge; tvalid stays up between back-to-back characters
  task automatic send_char(logic [7:0] c);
    while (idle_now()) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_char(c);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function string pick(bit sel, string a, string b);
    return sel ? a : b;
  endfunction

  function string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(48 + $urandom_range(9)))};
    return s;
  endfunction

  function string rand_junk(int n);
    string s;
    byte   b;
    s = "";
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (b == 0) b = 1;   // string cannot hold NUL; NUL sent separately
      s = {s, string'(b)};
    end
    return s;
  endfunction

  function string rand_sentence();
    string kinds[8];
    string s;
    kinds = '{"GSV", "RMC", "GSA", "GGA", "GLL", "VTG", "TXT", "XYZ"};
    s = {"$G", pick($urandom_range(1) != 0, "P", "N"), kinds[$urandom_range(7)]};
    if ($urandom_range(3) == 0) s = {s, "GGA"};
    s = {s, ",", rand_digits(6), ",",
         rand_digits($urandom_range(6)), pick($urandom_range(4) != 0, ".", ""),
         rand_digits($urandom_range(8)), ",",
         pick($urandom_range(2) == 0, "S", pick($urandom_range(1) != 0, "N", "")), ",",
         rand_digits($urandom_range(7)), ".", rand_digits($urandom_range(8)), ",",
         pick($urandom_range(2) == 0, "W", pick($urandom_range(1) != 0, "E", "")),
         ",1,08,0.9"};
    if ($urandom_range(9) == 0) s = {s, rand_junk($urandom_range(10))};
    return {s, "\r\n"};
  endfunction

  initial begin
    board.reset_state();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // directed lines: extremes, each kind, hemispheres, special cases
    calm = 1;
    send_text("$GPGGA,1,9999.99999,N,99999.99999,E\r\n");
    send_text("$GPGGA,1,9959.999999999,S,17959.99999,W\r\n");
    send_text("$GPGGA,,,,,,\r\n");
    send_text("$GPGSV\r\n$GPRMC,1\r\n$GPGSA,\r\n$GPGLL,\r\n$GPVTG,\r\n$GPTXT,\r\n");
    send_text("$GPGG,1\r\n$GPGGAX,1\r\n");
    calm = 0;
    send_text("$GPGGA,1,45a0.1x3,Q,1\r2\n34.5,E,\r\n");  // stray cr, lf alone
    send_char(8'd0); send_char(8'd255); send_text("\r\n");
    send_text({"$GPGGA,", rand_junk(100), "\r\n"});      // overflow, dropped
    send_text({"$GPTXT", rand_junk(85), "\r\n"});         // close to the limit
    send_text({",,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,", "\r\n"});
    // random part: mostly well-formed sentences, some noise
    while (chars_sent < 1150) begin
      if ($urandom_range(99) < 8) calm = 1;
      else if ($urandom_range(99) < 10) calm = 0;
      if ($urandom_range(9) < 8) send_text(rand_sentence());
      else begin
        send_text(rand_junk($urandom_range(20)));
        if ($urandom_range(1)) send_char(8'd0);
        if ($urandom_range(1)) send_text("\r\n");
      end
    end
    send_text("\r\n");
    s_axis_tvalid <= 0;
    while (board.exp_kind.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d characters, %0d line results, %0d position updates",
             chars_sent, board.lines_seen, board.gga_seen);
    if (board.errors == 0 && board.exp_kind.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
